/* design/refcounted_texture_slot_table_unit_macros.svh */
// Assertion helpers used by the checker file of the slot table.
`ifndef REFCOUNTED_TEXTURE_SLOT_TABLE_UNIT_MACROS_SVH
`define REFCOUNTED_TEXTURE_SLOT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define RTST_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define RTST_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define RTST_ASSERT_RST(label, pre, post, msg) \
    label: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/rtst_pkg.sv */
`timescale 1ns / 1ps
package rtst_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NF_W        = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int SLOT_W   = 7;
    localparam int ID_W     = 32;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request type codes on the input channel
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_LOOKUP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED           = 3'd0,
        ST_REUSED          = 3'd1,
        ST_FULL            = 3'd2,
        ST_DECREMENTED     = 3'd3,
        ST_FREED           = 3'd4,
        ST_IGNORED         = 3'd5,
        ST_LOOKUP_HIT      = 3'd6,
        ST_LOOKUP_FALLBACK = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FETCH,
        BK_EXEC
    } back_state_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic              removable;
        logic [SLOT_W-1:0] slot;
        logic              force_free;
    } cmd_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic               removable;
        logic [COUNT_W-1:0] count;
        logic [ID_W-1:0]    id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide < 32'(TABLE_DEPTH);
    endfunction

endpackage

/* design/rtst_ram.sv */
`timescale 1ns / 1ps
module rtst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/rtst_front.sv */
`timescale 1ns / 1ps
module rtst_front import rtst_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [ID_W-1:0]   s_resource_id,
    input  logic              s_is_removable,
    input  logic [SLOT_W-1:0] s_slot_index,
    input  logic              s_force_free,
    output logic              q_valid,
    input  logic              q_pop,
    output cmd_t              q_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    cmd_t cmd_in;
    logic known;
    logic push;

    // Classify the request; reserved codes are taken and dropped
    always_comb begin
        cmd_in.id         = s_resource_id;
        cmd_in.removable  = s_is_removable;
        cmd_in.slot       = s_slot_index;
        cmd_in.force_free = s_force_free;
        cmd_in.op         = OP_ADD;
        known             = 1'b1;
        case (s_req_type)
            REQ_ADD:    cmd_in.op = OP_ADD;
            REQ_REMOVE: cmd_in.op = OP_REMOVE;
            REQ_LOOKUP: cmd_in.op = OP_LOOKUP;
            default:    known = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && known;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* design/rtst_back.sv */
`timescale 1ns / 1ps
module rtst_back import rtst_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  cmd_t                q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_out,
    output logic [ID_W-1:0]     m_id_out,
    output logic [COUNT_W-1:0]  m_count_out
);

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;

    logic [NF_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                   chk_pending_reg, chk_pending_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [NF_W-1:0]        next_free_reg, next_free_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               res_load;
    status_t            res_status;
    logic [SLOT_W-1:0]  res_slot;
    logic [ID_W-1:0]    res_id;
    logic [COUNT_W-1:0] res_count;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wentry;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic               out_free;
    logic               start;
    logic               slot_ok;
    logic [IDX_W-1:0]   slot_idx;
    logic               slot_live;
    logic               scan_hit;
    logic               scan_more;
    logic               table_full;
    logic [IDX_W-1:0]   alloc_idx;
    logic [COUNT_W-1:0] inc_count;
    logic [COUNT_W-1:0] dec_count;

    rtst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Decode the current request against the table
    assign out_free   = !out_valid_reg || m_ready;
    assign start      = q_valid && out_free;
    assign slot_ok    = slot_in_range(cmd_reg.slot);
    assign slot_idx   = slot_to_idx(cmd_reg.slot);
    assign slot_live  = slot_ok && valid_reg[slot_idx];
    assign scan_hit   = chk_pending_reg && valid_reg[chk_idx_reg] && (rd_entry.id == cmd_reg.id);
    assign scan_more  = (scan_idx_reg < next_free_reg);
    assign table_full = (next_free_reg >= NF_W'(TABLE_DEPTH));
    assign alloc_idx  = next_free_reg[IDX_W-1:0];
    assign inc_count  = (rd_entry.count == COUNT_MAX) ? rd_entry.count
                                                      : rd_entry.count + COUNT_W'(1);
    assign dec_count  = (rd_entry.count != '0) ? rd_entry.count - COUNT_W'(1) : '0;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (start) begin
                    state_next = (q_cmd.op == OP_ADD) ? BK_SCAN : BK_FETCH;
                end
            end
            BK_SCAN: begin
                if (scan_hit || !scan_more) begin
                    state_next = BK_IDLE;
                end
            end
            BK_FETCH: state_next = BK_EXEC;
            BK_EXEC:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Datapath and memory control per state
    always_comb begin
        q_pop            = 1'b0;
        cmd_next         = cmd_reg;
        scan_idx_next    = scan_idx_reg;
        chk_pending_next = chk_pending_reg;
        chk_idx_next     = chk_idx_reg;
        next_free_next   = next_free_reg;
        valid_next       = valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wentry       = '0;
        ram_raddr        = '0;
        res_load         = 1'b0;
        res_status       = ST_ADDED;
        res_slot         = '0;
        res_id           = '0;
        res_count        = '0;
        case (state_reg)
            BK_IDLE: begin
                if (start) begin
                    q_pop            = 1'b1;
                    cmd_next         = q_cmd;
                    scan_idx_next    = '0;
                    chk_pending_next = 1'b0;
                end
            end
            BK_SCAN: begin
                if (scan_hit) begin
                    // Bump the matching entry, saturating
                    ram_we           = 1'b1;
                    ram_waddr        = chk_idx_reg;
                    ram_wentry       = '{removable: rd_entry.removable, count: inc_count,
                                         id: rd_entry.id};
                    chk_pending_next = 1'b0;
                    res_load         = 1'b1;
                    res_status       = ST_REUSED;
                    res_slot         = idx_to_slot(chk_idx_reg);
                    res_id           = cmd_reg.id;
                    res_count        = inc_count;
                end else if (scan_more) begin
                    // Issue the next read of the sweep
                    ram_raddr        = scan_idx_reg[IDX_W-1:0];
                    chk_pending_next = 1'b1;
                    chk_idx_next     = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next    = scan_idx_reg + NF_W'(1);
                end else if (table_full) begin
                    chk_pending_next = 1'b0;
                    res_load         = 1'b1;
                    res_status       = ST_FULL;
                end else begin
                    // Allocate a fresh slot
                    chk_pending_next     = 1'b0;
                    ram_we               = 1'b1;
                    ram_waddr            = alloc_idx;
                    ram_wentry           = '{removable: cmd_reg.removable,
                                             count: COUNT_W'(1), id: cmd_reg.id};
                    valid_next[alloc_idx] = 1'b1;
                    next_free_next       = next_free_reg + NF_W'(1);
                    res_load             = 1'b1;
                    res_status           = ST_ADDED;
                    res_slot             = idx_to_slot(alloc_idx);
                    res_id               = cmd_reg.id;
                    res_count            = COUNT_W'(1);
                end
            end
            BK_FETCH: begin
                // Lookup of an empty slot falls back to slot zero
                if (cmd_reg.op == OP_LOOKUP && !slot_live) begin
                    ram_raddr = '0;
                end else begin
                    ram_raddr = slot_idx;
                end
            end
            BK_EXEC: begin
                res_load = 1'b1;
                case (cmd_reg.op)
                    OP_REMOVE: begin
                        res_slot = cmd_reg.slot;
                        if (!slot_live || !rd_entry.removable) begin
                            res_status = ST_IGNORED;
                        end else if (dec_count == '0 || cmd_reg.force_free) begin
                            valid_next[slot_idx] = 1'b0;
                            res_status           = ST_FREED;
                            res_id               = rd_entry.id;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_idx;
                            ram_wentry = '{removable: rd_entry.removable, count: dec_count,
                                           id: rd_entry.id};
                            res_status = ST_DECREMENTED;
                            res_id     = rd_entry.id;
                            res_count  = dec_count;
                        end
                    end
                    OP_LOOKUP: begin
                        if (slot_live) begin
                            res_status = ST_LOOKUP_HIT;
                            res_slot   = cmd_reg.slot;
                            res_id     = rd_entry.id;
                            res_count  = rd_entry.count;
                        end else if (valid_reg[0]) begin
                            res_status = ST_LOOKUP_FALLBACK;
                            res_id     = rd_entry.id;
                            res_count  = rd_entry.count;
                        end else begin
                            res_status = ST_LOOKUP_FALLBACK;
                        end
                    end
                    default: res_load = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (res_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= BK_IDLE;
            chk_pending_reg <= 1'b0;
            next_free_reg   <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            chk_pending_reg <= chk_pending_next;
            next_free_reg   <= next_free_next;
            valid_reg       <= valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        if (res_load) begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_id_reg     <= res_id;
            out_count_reg  <= res_count;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_slot_out  = out_slot_reg;
    assign m_id_out    = out_id_reg;
    assign m_count_out = out_count_reg;

endmodule

/* design/refcounted_texture_slot_table_unit.sv */
`timescale 1ns / 1ps
// Channel   Ports                                    Carries
// request   s_valid/s_ready, s_req_type..s_force_free add, remove or lookup request
// result    m_valid/m_ready, m_status..m_count_out   one result per known request
//
// Remove and lookup go through the back end in order: dequeue, entry memory read,
// then update and register the result.
// Add sweeps the entry memory read port one slot per cycle over the slots handed
// out so far, stopping early on a hit.
// A two-entry request queue takes up to two requests while the back end works or a
// result waits; s_ready then drops until the back end dequeues one.
// Reset is synchronous; it clears all valid bits at once.
module refcounted_texture_slot_table_unit import rtst_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [ID_W-1:0]     s_resource_id,
    input  logic                s_is_removable,
    input  logic [SLOT_W-1:0]   s_slot_index,
    input  logic                s_force_free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_out,
    output logic [ID_W-1:0]     m_id_out,
    output logic [COUNT_W-1:0]  m_count_out
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Accept and classify requests
    rtst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_resource_id  (s_resource_id),
        .s_is_removable (s_is_removable),
        .s_slot_index   (s_slot_index),
        .s_force_free   (s_force_free),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_cmd          (q_cmd)
    );

    // Carry out requests against the table
    rtst_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot_out  (m_slot_out),
        .m_id_out    (m_id_out),
        .m_count_out (m_count_out)
    );

endmodule

/* design/rtst_checker.sv */
`timescale 1ns / 1ps
`include "refcounted_texture_slot_table_unit_macros.svh"
module rtst_checker import rtst_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [SLOT_W-1:0]   m_slot_out,
    input logic [ID_W-1:0]     m_id_out,
    input logic [COUNT_W-1:0]  m_count_out
);

    // Stalled result holds
    `RTST_ASSERT_NXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot_out) && $stable(m_id_out) && $stable(m_count_out), "result changed while stalled")

    // Reset drops any pending result
    `RTST_ASSERT_RST(a_reset_idle, !aresetn, !m_valid, "result valid after reset")

    // Full answer carries no slot
    `RTST_ASSERT_IMP(a_full_zero, m_valid && (m_status == ST_FULL), (m_slot_out == '0) && (m_id_out == '0) && (m_count_out == '0), "full result not zero")

    // New entry starts at one use, freed or ignored at none
    `RTST_ASSERT_IMP(a_count_code, m_valid, ((m_status != ST_ADDED) || (m_count_out == 16'd1)) && ((m_status != ST_FREED && m_status != ST_IGNORED) || (m_count_out == '0)), "count does not match status")

endmodule

bind refcounted_texture_slot_table_unit rtst_checker u_checker (.*);
